>>> src/sdu_pkg.sv
// ----------------------------------------------------------------------------
// sdu_pkg: shared types and constants of the sorted distinct union unit
// Beat types, cell control and controller states.
// ----------------------------------------------------------------------------
package sdu_pkg;

  // Number of sorting cells, i.e. how many values one run can hold
  localparam int unsigned CAPACITY = 64;
  // Fill count width, wide enough to hold CAPACITY itself
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);

  // Input beat
  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } sdu_in_t;

  // Result beat
  typedef struct packed {
    logic signed [31:0] value_res;
    logic               is_final;
    logic               overflow;
  } sdu_out_t;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value in sorted position
    logic shift;   // move every value one cell toward the head
  } sdu_cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } sdu_state_e;

endpackage

>>> src/sdu_cell.sv
// ----------------------------------------------------------------------------
// sdu_cell: one cell of the insertion sorting chain
// Holds one value; takes the new value, its left neighbor's value or its
// right neighbor's value depending on the chain command.
// ----------------------------------------------------------------------------
module sdu_cell
  import sdu_pkg::*;
(
  input  logic               clk_i,
  input  sdu_cell_ctrl_t     ctrl_i,
  input  logic signed [31:0] new_val_i,   // broadcast value being inserted
  input  logic               occ_i,       // this cell holds a stored value
  input  logic               prev_lt_i,   // left neighbor: new value goes at or before it
  input  logic signed [31:0] prev_val_i,  // left neighbor's value
  input  logic signed [31:0] next_val_i,  // right neighbor's value
  output logic               lt_o,        // new value goes at or before this cell
  output logic signed [31:0] val_o
);

  logic signed [31:0] val_q, val_d;

  // New value belongs in front of this cell if the cell is empty or larger
  assign lt_o = !occ_i || (new_val_i < val_q);

  // Insert shifts larger values right; emission shifts everything left
  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert) begin
      if (lt_o) begin
        val_d = prev_lt_i ? prev_val_i : new_val_i;
      end
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

>>> src/sorted_distinct_union_unit.sv
// ----------------------------------------------------------------------------
// sorted_distinct_union_unit: sort and deduplicate a stream of signed values
// Collects up to CAPACITY values in a sorting chain and, on the last beat,
// plays out the distinct values in ascending signed order.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a beat is taken at a clock edge with start high and busy low.
//   While collecting, one beat is taken every cycle; each value is placed in
//   sorted position across the cell chain in that same cycle. Values that
//   arrive with the chain full are dropped and flag the run as overflowed.
//   The beat with is_last set closes the run: busy rises and the chain
//   shifts one value per cycle toward the head. A one-entry holding stage
//   drops repeats and looks ahead one value to mark is_final.
//   Output: each result shows on result_o for one cycle with result_valid_o
//   high; the receiver cannot stall it.
//   Drain order: each head value shifted out enters the holding stage; a
//   held value is registered to result_o once a different value follows it
//   (so repeats of the smallest values delay the first result), the value
//   held when the chain empties is the final result, and busy falls together with the final result.
//   The chain length (CAPACITY cells) bounds how many values a run stores.
//   Reset: clears the fill count, overflow flag and controller; the chain
//   contents need no reset.
// ----------------------------------------------------------------------------
module sorted_distinct_union_unit
  import sdu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sdu_in_t  item_i,
  output logic     result_valid_o,
  output sdu_out_t result_o
);

  sdu_state_e      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic signed [31:0] pend_q, pend_d;
  logic            pend_vld_q, pend_vld_d;
  logic            out_vld_q, out_vld_d;
  sdu_out_t        out_q, out_d;
  sdu_cell_ctrl_t  ctrl;
  logic            accept;

  logic signed [31:0] cell_val [CAPACITY];
  logic               cell_lt  [CAPACITY];
  logic signed [31:0] head;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign head   = cell_val[0];

  // Sorting chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               occ;
    logic               prev_lt;
    logic signed [31:0] prev_val;
    logic signed [31:0] next_val;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_lt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_lt  = cell_lt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    sdu_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_val_i  (item_i.value),
      .occ_i      (occ),
      .prev_lt_i  (prev_lt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .lt_o       (cell_lt[i]),
      .val_o      (cell_val[i])
    );
  end

  // Controller: collect, then drain with repeat removal and one-value lookahead
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    drop_d     = drop_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_vld_d  = 1'b0;
    out_d      = out_q;
    ctrl       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < CntW'(CAPACITY)) begin
            ctrl.insert = 1'b1;
            count_d     = count_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (item_i.is_last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (count_q != '0) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - CntW'(1);
          pend_d     = head;
          pend_vld_d = 1'b1;
          if (pend_vld_q && (head != pend_q)) begin
            out_vld_d       = 1'b1;
            out_d.value_res = pend_q;
            out_d.is_final  = 1'b0;
            out_d.overflow  = drop_q;
          end
        end else begin
          out_vld_d       = 1'b1;
          out_d.value_res = pend_q;
          out_d.is_final  = 1'b1;
          out_d.overflow  = drop_q;
          pend_vld_d      = 1'b0;
          drop_d          = 1'b0;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      drop_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      drop_q     <= drop_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

  // Fill count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count beyond chain length");

  // Nothing held in the lookahead stage between runs
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("lookahead stage holds a value while idle");

  // Results within a run rise strictly
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(result_valid_o) && !$past(result_o.is_final))
      |-> ($past(result_o.value_res) < result_o.value_res))
    else $error("results not strictly ascending");

  // A final result is never directly followed by another result
  a_final_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.is_final) |=> !result_valid_o)
    else $error("result right after final result");

endmodule

>>> tb/sv/sorted_distinct_union_unit_test.sv
// ----------------------------------------------------------------------------
// sorted_distinct_union_unit_test: self-checking bench for the sort/dedup unit
// Streams runs of signed values into the unit and predicts each run's sorted,
// deduplicated output with an in-bench model. Covers extreme values,
// duplicates, arbitrary ordering and store overflow, then random runs under
// changing sender gap rates. Every result beat is checked field by field.
// ----------------------------------------------------------------------------
module sorted_distinct_union_unit_test;
  import sdu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TargetBeats = 500;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  sdu_in_t  item_i;
  logic     result_valid_o;
  sdu_out_t result_o;

  // Prediction state: values held for the current run, drop flag, results due
  logic signed [31:0] held_values[$];
  bit                 held_dropped;
  sdu_out_t           pending_results[$];

  int err_count   = 0;
  int beats_sent  = 0;
  int gap_pct     = 0;

  sorted_distinct_union_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hard stop in case the unit hangs
  initial begin
    #5ms;
    $display("sorted_distinct_union_unit_test: errors");
    $finish;
  end

  // Sort held values ascending (signed), drop repeats, queue the results
  function automatic void emit_sorted_distinct();
    logic signed [31:0] ordered[$];
    logic signed [31:0] distinct[$];
    logic signed [31:0] x;
    int                 j;
    sdu_out_t           res;
    foreach (held_values[i]) begin
      x = held_values[i];
      ordered.push_back(x);
      j = ordered.size() - 1;
      while (j > 0 && x < ordered[j-1]) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = x;
    end
    foreach (ordered[i]) begin
      if (distinct.size() == 0 || ordered[i] != distinct[distinct.size()-1]) begin
        distinct.push_back(ordered[i]);
      end
    end
    foreach (distinct[i]) begin
      res.value_res = distinct[i];
      res.is_final  = (i == distinct.size() - 1);
      res.overflow  = held_dropped;
      pending_results.push_back(res);
    end
    held_values.delete();
    held_dropped = 1'b0;
  endfunction

  // Update the model with one accepted beat
  function automatic void fold_beat(sdu_in_t beat);
    if (held_values.size() < CAPACITY) begin
      held_values.push_back(beat.value);
    end else begin
      held_dropped = 1'b1;
    end
    if (beat.is_last) begin
      emit_sorted_distinct();
    end
  endfunction

  // Drive one beat, with random sender gaps, and hold it until taken
  task automatic send_beat(input logic signed [31:0] v, input bit last);
    sdu_in_t beat;
    beat.value   = v;
    beat.is_last = last;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= beat;
    do @(posedge clk_i); while (busy);
    fold_beat(beat);
    beats_sent++;
  endtask

  // Stop sending until every predicted result has come out
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random value: small range for repeats, full range, or extremes
  function automatic logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return int'($urandom_range(15)) - 8;
      1: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // Check every result beat against the oldest prediction
  always @(posedge clk_i) begin : result_check
    sdu_out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value_res=%0d is_final=%0b overflow=%0b",
                 $time, result_o.value_res, result_o.is_final, result_o.overflow);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.value_res !== want.value_res) begin
          $display("%0t: value_res mismatch: expected %0d, actual %0d",
                   $time, want.value_res, result_o.value_res);
          err_count++;
        end
        if (result_o.is_final !== want.is_final) begin
          $display("%0t: is_final mismatch: expected %0b, actual %0b",
                   $time, want.is_final, result_o.is_final);
          err_count++;
        end
        if (result_o.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch: expected %0b, actual %0b",
                   $time, want.overflow, result_o.overflow);
          err_count++;
        end
      end
    end
  end

  // A lone last beat gives exactly one final result
  task automatic test_single_value();
    send_beat(32'sd5, 1'b1);
    send_beat(-32'sd77, 1'b1);
  endtask

  // Extremes of the signed range, adjacent min/max must not wrap
  task automatic test_extremes();
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd1, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b1);
    wait_drained();
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b1);
  endtask

  // All-equal run collapses to one value
  task automatic test_duplicates();
    repeat (4) send_beat(32'sd7, 1'b0);
    send_beat(32'sd7, 1'b1);
  endtask

  // Unordered input with repeats on both sides of zero
  task automatic test_ordering();
    send_beat(32'sd3, 1'b0);
    send_beat(-32'sd2, 1'b0);
    send_beat(32'sd3, 1'b0);
    send_beat(32'sd100, 1'b0);
    send_beat(-32'sd2, 1'b0);
    send_beat(-32'sd100, 1'b1);
  endtask

  // Full store without drop, then drops including a dropped last beat
  task automatic test_capacity();
    wait_drained();
    for (int i = 0; i < CAPACITY - 1; i++) send_beat(300 - 7 * i, 1'b0);
    send_beat(-32'sd999, 1'b1);
    wait_drained();
    for (int i = 0; i < CAPACITY + 5; i++) send_beat(pick_value(0), 1'b0);
    send_beat(32'sd12345, 1'b1);
    for (int i = 0; i < CAPACITY + 1; i++) send_beat(pick_value(1), 1'b0);
    send_beat(pick_value(2), 1'b1);
  endtask

  // Random runs: mostly short, some long, a few past capacity
  task automatic test_random_runs();
    int run_len;
    int mode;
    int runs;
    int sel;
    runs = 0;
    while (beats_sent < TargetBeats) begin
      if (beats_sent < 250) gap_pct = 15;
      else if (beats_sent < 400) gap_pct = 64;
      else gap_pct = 0;
      sel = $urandom_range(99);
      if (sel < 85) run_len = $urandom_range(1, 12);
      else if (sel < 96) run_len = $urandom_range(13, CAPACITY);
      else run_len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      mode = $urandom_range(2);
      for (int i = 0; i < run_len; i++) begin
        send_beat(pick_value(mode), i == run_len - 1);
      end
      runs++;
      if (runs % 9 == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_value();
    test_extremes();
    test_duplicates();
    test_ordering();
    test_capacity();
    test_random_runs();

    wait_drained();
    repeat (CAPACITY + 4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("sorted_distinct_union_unit_test: clean");
    end else begin
      $display("sorted_distinct_union_unit_test: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sdu_pkg.sv
src/sdu_cell.sv
src/sorted_distinct_union_unit.sv
tb/sv/sorted_distinct_union_unit_test.sv
